FILE: sv/terminal_key_sequence_decoder_macros.svh
// ----------------------------------------------------------------------------
// Terminal key sequence decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TKSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TKSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tksd_pkg.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Parser modes, key codes and character constants
// ----------------------------------------------------------------------------
package tksd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2,
    MODE_UTF8 = 2'd3
  } mode_t;

  // request commands
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_RESIZE = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // key codes
  localparam logic [4:0] KC_PLAIN  = 5'd0;
  localparam logic [4:0] KC_ESC    = 5'd1;
  localparam logic [4:0] KC_UP     = 5'd2;
  localparam logic [4:0] KC_DOWN   = 5'd3;
  localparam logic [4:0] KC_RIGHT  = 5'd4;
  localparam logic [4:0] KC_LEFT   = 5'd5;
  localparam logic [4:0] KC_HOME   = 5'd6;
  localparam logic [4:0] KC_END    = 5'd7;
  localparam logic [4:0] KC_ENTER  = 5'd8;
  localparam logic [4:0] KC_F1     = 5'd9;
  localparam logic [4:0] KC_F2     = 5'd10;
  localparam logic [4:0] KC_F3     = 5'd11;
  localparam logic [4:0] KC_F4     = 5'd12;
  localparam logic [4:0] KC_SUP    = 5'd13;
  localparam logic [4:0] KC_SDOWN  = 5'd14;
  localparam logic [4:0] KC_DEL    = 5'd15;
  localparam logic [4:0] KC_PGUP   = 5'd16;
  localparam logic [4:0] KC_PGDN   = 5'd17;
  localparam logic [4:0] KC_BKSP   = 5'd18;
  localparam logic [4:0] KC_UTF8   = 5'd19;
  localparam logic [4:0] KC_RESIZE = 5'd20;
  localparam logic [4:0] KC_ERROR  = 5'd21;

  // characters
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SS3     = 8'h4F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [15:0] DELAY_RESET = 16'd25;

  function automatic logic [4:0] cursor_letter(input logic [7:0] c);
    logic [4:0] k;
    begin
      case (c)
        8'h41:   k = KC_UP;
        8'h42:   k = KC_DOWN;
        8'h43:   k = KC_RIGHT;
        8'h44:   k = KC_LEFT;
        8'h48:   k = KC_HOME;
        8'h46:   k = KC_END;
        default: k = KC_ERROR;
      endcase
      return k;
    end
  endfunction

  function automatic logic ends_seq(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_TILDE);
  endfunction

  function automatic logic [4:0] tilde_key(input logic [7:0] t);
    logic [4:0] k;
    begin
      case (t)
        8'd1:    k = KC_HOME;
        8'd3:    k = KC_DEL;
        8'd4:    k = KC_END;
        8'd5:    k = KC_PGUP;
        8'd6:    k = KC_PGDN;
        8'd11:   k = KC_F1;
        8'd12:   k = KC_F2;
        8'd13:   k = KC_F3;
        8'd14:   k = KC_F4;
        default: k = KC_ERROR;
      endcase
      return k;
    end
  endfunction

endpackage

FILE: sv/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns terminal bytes, ticks, resize and end notices into key events
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the result register is empty
// or being drained; a request that yields a key shows it on the out channel
// in the cycle after acceptance. Throughput is set by the single result
// register: a stalled out_ready holds in_ready low only once a key waits
// there. The escape buffer, tilde number, silence counter and UTF-8 group
// are updated in the same cycle the request is accepted.
`include "terminal_key_sequence_decoder_macros.svh"

module terminal_key_sequence_decoder import tksd_pkg::*; #(
  parameter int SEQ_MAX = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_key_code,
  output logic [7:0]  out_plain_byte,
  output logic [7:0]  out_utf8_byte0,
  output logic [7:0]  out_utf8_byte1,
  output logic [7:0]  out_utf8_byte2,
  output logic [7:0]  out_utf8_byte3,
  output logic [2:0]  out_utf8_count
);

  localparam int LEN_W = $clog2(SEQ_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SEQ_MAX);

  mode_t            mode_r, mode_nxt;
  logic [15:0]      delay_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [4:0][7:0]  head_r, head_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       tilde_r, tilde_nxt;
  logic [15:0]      sil_r, sil_nxt;
  logic [3:0][7:0]  utf_r, utf_nxt;
  logic [2:0]       gath_r, gath_nxt;
  logic [2:0]       exp_r, exp_nxt;

  logic             seq_close, utf_emit;
  logic             in_acc, is_byte, is_tick, is_digit;
  logic [11:0]      tilde_calc;
  logic [7:0]       tilde_sat;

  logic             res_valid;
  logic [4:0]       res_key;
  logic [7:0]       res_plain;
  logic [3:0][7:0]  res_utf;
  logic [2:0]       res_cnt;

  logic             out_valid_r;
  logic [4:0]       key_r;
  logic [7:0]       plain_r;
  logic [3:0][7:0]  outb_r;
  logic [2:0]       cnt_r;

  function automatic logic [4:0] decode_seq(
    input logic [LEN_W-1:0] n,
    input logic [4:0][7:0]  hd,
    input logic [7:0]       lastb,
    input logic [7:0]       tnum
  );
    logic [4:0] k;
    logic [4:0] kc;
    logic [4:0] kt;
    begin
      k  = KC_ESC;
      kc = cursor_letter(hd[1]);
      kt = tilde_key(tnum);
      if (n >= LEN_W'(2) && hd[0] == CH_SS3) begin
        if (kc != KC_ERROR) k = kc;
        else begin
          case (hd[1])
            8'h4D:   k = KC_ENTER;
            8'h50:   k = KC_F1;
            8'h51:   k = KC_F2;
            8'h52:   k = KC_F3;
            8'h53:   k = KC_F4;
            default: k = KC_ESC;
          endcase
        end
      end else if (n >= LEN_W'(2) && hd[0] == CH_LBRACK) begin
        if (n == LEN_W'(2) && kc != KC_ERROR) k = kc;
        else if (n == LEN_W'(2) && hd[1] == 8'h61) k = KC_SUP;
        else if (n == LEN_W'(2) && hd[1] == 8'h62) k = KC_SDOWN;
        else if (lastb == CH_TILDE && kt != KC_ERROR) k = kt;
        else if (n >= LEN_W'(5) && hd[1] == CH_ONE && hd[2] == CH_SEMI &&
                 hd[3] == CH_TWO && hd[4] == 8'h41) k = KC_SUP;
        else if (n >= LEN_W'(5) && hd[1] == CH_ONE && hd[2] == CH_SEMI &&
                 hd[3] == CH_TWO && hd[4] == 8'h42) k = KC_SDOWN;
      end
      return k;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign is_byte   = (in_command == CMD_BYTE);
  assign is_tick   = (in_command == CMD_TICK);
  assign is_digit  = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);

  // decimal accumulate: tilde * 10 + digit, clamped to 255
  assign tilde_calc = ({4'd0, tilde_r} << 3) + ({4'd0, tilde_r} << 1) +
                      {4'd0, in_data_byte - CH_ZERO};
  assign tilde_sat  = (tilde_calc > 12'd255) ? 8'd255 : tilde_calc[7:0];

  // state datapath
  always_comb begin
    len_nxt   = len_r;
    head_nxt  = head_r;
    last_nxt  = last_r;
    tilde_nxt = tilde_r;
    sil_nxt   = sil_r;
    utf_nxt   = utf_r;
    gath_nxt  = gath_r;
    exp_nxt   = exp_r;
    seq_close = 1'b0;
    utf_emit  = 1'b0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (is_byte && in_data_byte == CH_ESC) begin
          len_nxt   = '0;
          tilde_nxt = '0;
          sil_nxt   = '0;
        end else if (is_byte && in_data_byte >= UTF8_LEAD2) begin
          exp_nxt    = (in_data_byte >= UTF8_LEAD4) ? 3'd4 :
                       (in_data_byte >= UTF8_LEAD3) ? 3'd3 : 3'd2;
          utf_nxt[0] = in_data_byte;
          gath_nxt   = 3'd1;
        end
      end
      MODE_UTF8: begin
        if (is_byte) begin
          // gathered count stays 1..3 while a group is open
          utf_nxt[gath_r[1:0]] = in_data_byte;
          gath_nxt = gath_r + 3'd1;
          utf_emit = !((gath_nxt < exp_r) && (gath_nxt < 3'd4));
        end else if (!is_tick) begin
          utf_emit = 1'b1;
        end
      end
      MODE_ESC, MODE_SEQ: begin
        if (is_tick) begin
          sil_nxt   = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
          seq_close = (sil_nxt >= delay_r);
        end else if (is_byte) begin
          sil_nxt = '0;
          if (len_r < LEN_MAX) begin
            for (int k = 0; k < 5; k++) begin
              if (len_r == LEN_W'(k)) head_nxt[k] = in_data_byte;
            end
            last_nxt = in_data_byte;
            len_nxt  = len_r + LEN_W'(1);
          end
          if (is_digit && len_nxt > LEN_W'(1)) tilde_nxt = tilde_sat;
          if (mode_r == MODE_ESC) begin
            seq_close = !(in_data_byte == CH_LBRACK || in_data_byte == CH_SS3);
          end else begin
            seq_close = ends_seq(in_data_byte) || (len_nxt >= LEN_MAX);
          end
        end else begin
          seq_close = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next parse mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_IDLE: begin
        if (is_byte && in_data_byte == CH_ESC) mode_nxt = MODE_ESC;
        else if (is_byte && in_data_byte >= UTF8_LEAD2) mode_nxt = MODE_UTF8;
      end
      MODE_UTF8: if (utf_emit) mode_nxt = MODE_IDLE;
      MODE_ESC: begin
        if (seq_close) mode_nxt = MODE_IDLE;
        else if (is_byte) mode_nxt = MODE_SEQ;
      end
      MODE_SEQ: if (seq_close) mode_nxt = MODE_IDLE;
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  // key result
  always_comb begin
    res_valid = 1'b0;
    res_key   = KC_PLAIN;
    res_plain = '0;
    res_utf   = '0;
    res_cnt   = '0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_command == CMD_RESIZE) begin
          res_valid = 1'b1;
          res_key   = KC_RESIZE;
        end else if (in_command == CMD_END) begin
          res_valid = 1'b1;
          res_key   = KC_ERROR;
        end else if (is_byte && in_data_byte == CH_DEL) begin
          res_valid = 1'b1;
          res_key   = KC_BKSP;
        end else if (is_byte && in_data_byte != CH_ESC && in_data_byte < UTF8_LEAD2) begin
          res_valid = 1'b1;
          res_plain = in_data_byte;
        end
      end
      MODE_UTF8: begin
        if (utf_emit) begin
          res_valid = 1'b1;
          res_key   = KC_UTF8;
          res_cnt   = gath_nxt;
          for (int i = 0; i < 4; i++) begin
            if (gath_nxt > 3'(i)) res_utf[i] = utf_nxt[i];
          end
        end
      end
      MODE_ESC, MODE_SEQ: begin
        if (seq_close) begin
          res_valid = 1'b1;
          res_key   = decode_seq(len_nxt, head_nxt, last_nxt, tilde_nxt);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      delay_r     <= DELAY_RESET;
      len_r       <= '0;
      tilde_r     <= '0;
      sil_r       <= '0;
      gath_r      <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) delay_r <= cfg_data;
      if (in_acc) begin
        mode_r  <= mode_nxt;
        len_r   <= len_nxt;
        tilde_r <= tilde_nxt;
        sil_r   <= sil_nxt;
        gath_r  <= gath_nxt;
        exp_r   <= exp_nxt;
      end
      if (in_acc && res_valid) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      head_r <= head_nxt;
      last_r <= last_nxt;
      utf_r  <= utf_nxt;
    end
    if (in_acc && res_valid) begin
      key_r   <= res_key;
      plain_r <= res_plain;
      outb_r  <= res_utf;
      cnt_r   <= res_cnt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = key_r;
  assign out_plain_byte = plain_r;
  assign out_utf8_byte0 = outb_r[0];
  assign out_utf8_byte1 = outb_r[1];
  assign out_utf8_byte2 = outb_r[2];
  assign out_utf8_byte3 = outb_r[3];
  assign out_utf8_count = cnt_r;

  `TKSD_ASSERT_NOW(a_seq_len, clk, rst_n, mode_r == MODE_SEQ,
    len_r >= LEN_W'(1) && len_r < LEN_MAX, "sequence length out of range")
  `TKSD_ASSERT_NOW(a_utf_gath, clk, rst_n, mode_r == MODE_UTF8,
    gath_r >= 3'd1 && gath_r < exp_r, "utf8 gathered count out of range")
  `TKSD_ASSERT_NOW(a_utf_cnt, clk, rst_n, out_valid_r && key_r == KC_UTF8,
    cnt_r >= 3'd1 && cnt_r <= 3'd4, "utf8 key with bad count")
  `TKSD_ASSERT_NOW(a_non_utf, clk, rst_n, out_valid_r && key_r != KC_UTF8,
    cnt_r == 3'd0 && outb_r == '0, "utf8 fields set on non-utf8 key")
  `TKSD_ASSERT_NEXT(a_esc_enter, clk, rst_n,
    in_acc && mode_r == MODE_IDLE && is_byte && in_data_byte == CH_ESC,
    mode_r == MODE_ESC && !out_valid_r, "escape did not open a sequence")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Feeds byte, tick, resize and end requests through the decoder under random
// stalls on both sides. Each accepted request is run through a local model
// of the decoder; every key event must match the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
  import tksd_pkg::*;

  localparam int SEQ_DEPTH   = 15;
  localparam int DRAIN_PAD   = 3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [4:0] code;
    logic [7:0] plain;
    logic [7:0] u0;
    logic [7:0] u1;
    logic [7:0] u2;
    logic [7:0] u3;
    logic [2:0] count;
  } key_event_t;

  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED} rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_BYTE;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_key_code;
  logic [7:0]  out_plain_byte;
  logic [7:0]  out_utf8_byte0;
  logic [7:0]  out_utf8_byte1;
  logic [7:0]  out_utf8_byte2;
  logic [7:0]  out_utf8_byte3;
  logic [2:0]  out_utf8_count;

  terminal_key_sequence_decoder #(.SEQ_MAX(SEQ_DEPTH)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_code   (out_key_code),
    .out_plain_byte (out_plain_byte),
    .out_utf8_byte0 (out_utf8_byte0),
    .out_utf8_byte1 (out_utf8_byte1),
    .out_utf8_byte2 (out_utf8_byte2),
    .out_utf8_byte3 (out_utf8_byte3),
    .out_utf8_count (out_utf8_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // decoder model state
  mode_t      parse_state = MODE_IDLE;
  logic [7:0] seq_buf [SEQ_DEPTH];
  int         seq_len = 0;
  int         tilde_value = 0;
  int         silence = 0;
  logic [7:0] u8_buf [4];
  int         u8_need = 0;
  int         u8_got = 0;
  int         delay_ticks = int'(DELAY_RESET);

  request_t   request_queue [$];
  key_event_t pending_keys [$];
  int         queued = 0;
  int         mismatches = 0;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   style_left = 0;
  rx_style_t rx_style = RX_OPEN;
  int   quiet_cycles = 0;

  function automatic bit is_final_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_TILDE;
  endfunction

  function automatic logic [4:0] classify_sequence();
    logic [7:0] lead;
    logic [7:0] second;
    if (seq_len < 2) return KC_ESC;
    lead = seq_buf[0];
    second = seq_buf[1];
    if (lead == CH_SS3) begin
      case (second)
        "A": return KC_UP;
        "B": return KC_DOWN;
        "C": return KC_RIGHT;
        "D": return KC_LEFT;
        "H": return KC_HOME;
        "F": return KC_END;
        "M": return KC_ENTER;
        "P": return KC_F1;
        "Q": return KC_F2;
        "R": return KC_F3;
        "S": return KC_F4;
        default: ;
      endcase
    end
    if (lead == CH_LBRACK) begin
      if (seq_len == 2) begin
        case (second)
          "A": return KC_UP;
          "B": return KC_DOWN;
          "C": return KC_RIGHT;
          "D": return KC_LEFT;
          "H": return KC_HOME;
          "F": return KC_END;
          "a": return KC_SUP;
          "b": return KC_SDOWN;
          default: ;
        endcase
      end
      if (seq_buf[seq_len - 1] == CH_TILDE) begin
        case (tilde_value)
          1:  return KC_HOME;
          3:  return KC_DEL;
          4:  return KC_END;
          5:  return KC_PGUP;
          6:  return KC_PGDN;
          11: return KC_F1;
          12: return KC_F2;
          13: return KC_F3;
          14: return KC_F4;
          default: ;
        endcase
      end
      // shift-modified cursor form 1;2A / 1;2B
      if (seq_len >= 5 && second == CH_ONE && seq_buf[2] == CH_SEMI && seq_buf[3] == CH_TWO) begin
        if (seq_buf[4] == "A") return KC_SUP;
        if (seq_buf[4] == "B") return KC_SDOWN;
      end
    end
    return KC_ESC;
  endfunction

  function automatic void decode_request(input logic [1:0] cmd, input logic [7:0] b,
                                         output bit produced, output key_event_t ev);
    bit close;
    int t;
    ev = '0;
    produced = 1'b0;
    case (parse_state)
      MODE_IDLE: begin
        if (cmd == CMD_RESIZE) begin
          ev.code = KC_RESIZE;
          produced = 1'b1;
        end else if (cmd == CMD_END) begin
          ev.code = KC_ERROR;
          produced = 1'b1;
        end else if (cmd == CMD_BYTE) begin
          if (b == CH_ESC) begin
            parse_state = MODE_ESC;
            seq_len = 0;
            tilde_value = 0;
            silence = 0;
          end else if (b == CH_DEL) begin
            ev.code = KC_BKSP;
            produced = 1'b1;
          end else if (b >= UTF8_LEAD2) begin
            u8_need = (b >= UTF8_LEAD4) ? 4 : (b >= UTF8_LEAD3) ? 3 : 2;
            u8_buf[0] = b;
            u8_got = 1;
            parse_state = MODE_UTF8;
          end else begin
            ev.code = KC_PLAIN;
            ev.plain = b;
            produced = 1'b1;
          end
        end
      end
      MODE_UTF8: begin
        if (cmd != CMD_TICK) begin
          close = 1'b1;
          if (cmd == CMD_BYTE) begin
            if (u8_got < 4) u8_buf[u8_got] = b;
            u8_got++;
            if (u8_got < u8_need && u8_got < 4) close = 1'b0;
          end
          if (close) begin
            ev.code = KC_UTF8;
            ev.u0 = (u8_got > 0) ? u8_buf[0] : 8'h00;
            ev.u1 = (u8_got > 1) ? u8_buf[1] : 8'h00;
            ev.u2 = (u8_got > 2) ? u8_buf[2] : 8'h00;
            ev.u3 = (u8_got > 3) ? u8_buf[3] : 8'h00;
            ev.count = u8_got[2:0];
            parse_state = MODE_IDLE;
            produced = 1'b1;
          end
        end
      end
      default: begin
        close = 1'b1;
        if (cmd == CMD_TICK) begin
          if (silence < 16'hFFFF) silence++;
          if (silence < delay_ticks) close = 1'b0;
        end else if (cmd == CMD_BYTE) begin
          silence = 0;
          if (seq_len < SEQ_DEPTH) begin
            seq_buf[seq_len] = b;
            seq_len++;
          end
          // the byte right after ESC never feeds the tilde number
          if (b >= CH_ZERO && b <= CH_NINE && seq_len > 1) begin
            t = tilde_value * 10 + (b - CH_ZERO);
            tilde_value = (t > 255) ? 255 : t;
          end
          if (parse_state == MODE_ESC) begin
            if (b == CH_LBRACK || b == CH_SS3) begin
              parse_state = MODE_SEQ;
              close = 1'b0;
            end
          end else if (!is_final_byte(b) && seq_len < SEQ_DEPTH) begin
            close = 1'b0;
          end
        end
        if (close) begin
          ev.code = classify_sequence();
          parse_state = MODE_IDLE;
          produced = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // request driver: bursts with random gaps
  always @(negedge clk) begin : driver
    logic     next_valid;
    request_t req;
    next_valid = 1'b0;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (in_valid && !in_taken) begin
      next_valid = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (request_queue.size() > 0) begin
      req = request_queue.pop_front();
      in_command <= req.cmd;
      in_data_byte <= req.data;
      next_valid = 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 20);
        gap_left = $urandom_range(0, 6);
      end
    end
    in_valid <= next_valid;
  end

  // key receiver: stall style changes now and then, plus requested long hold-offs
  always @(negedge clk) begin : receiver
    logic next_ready;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 2));
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      case (rx_style)
        RX_OPEN: next_ready = 1'b1;
        RX_BUSY: next_ready = ($urandom_range(0, 3) != 0);
        default: next_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready <= next_ready;
  end

  always @(posedge clk) begin : monitor
    bit         produced;
    key_event_t ev;
    key_event_t want;
    in_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) delay_ticks = int'(cfg_data);
      if (in_valid && in_ready) begin
        decode_request(in_command, in_data_byte, produced, ev);
        if (produced) pending_keys.push_back(ev);
      end
      if (out_valid && out_ready) begin
        if (pending_keys.size() == 0) begin
          $error("key event with none predicted: key_code %0d", out_key_code);
          mismatches++;
        end else begin
          want = pending_keys.pop_front();
          check_field("key_code", 8'(want.code), 8'(out_key_code));
          check_field("plain_byte", want.plain, out_plain_byte);
          check_field("utf8_byte0", want.u0, out_utf8_byte0);
          check_field("utf8_byte1", want.u1, out_utf8_byte1);
          check_field("utf8_byte2", want.u2, out_utf8_byte2);
          check_field("utf8_byte3", want.u3, out_utf8_byte3);
          check_field("utf8_count", 8'(want.count), 8'(out_utf8_count));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_request(input logic [1:0] cmd, input logic [7:0] b);
    request_t req;
    req.cmd = cmd;
    req.data = b;
    request_queue.push_back(req);
    queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_request(CMD_BYTE, b);
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_request(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_char(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic queue_random_unit();
    int         pick;
    int         n;
    int         need;
    int         cap;
    logic [7:0] lead;
    logic [7:0] body [$];
    string      digits;
    pick = $urandom_range(0, 99);
    // ticks that stay below the escape delay inside a well-formed sequence
    cap = (delay_ticks == 0) ? 0 : ((delay_ticks > 8) ? 8 : delay_ticks - 1);
    if (pick < 20) begin
      queue_byte(8'($urandom_range(0, 255)));
    end else if (pick < 24) begin
      queue_byte(CH_DEL);
    end else if (pick < 38) begin
      lead = 8'($urandom_range(UTF8_LEAD2, 255));
      need = (lead >= UTF8_LEAD4) ? 4 : (lead >= UTF8_LEAD3) ? 3 : 2;
      queue_byte(lead);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, need - 2) : need - 1;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) queue_ticks($urandom_range(1, 3));
        queue_byte(8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(8'h80, 8'hBF)));
      end
      // cut short by a resize or end notice
      if (n < need - 1)
        queue_request($urandom_range(0, 1) ? CMD_RESIZE : CMD_END,
                      8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      queue_byte(CH_ESC);
      case ($urandom_range(0, 6))
        0: begin
          body.push_back(CH_LBRACK);
          body.push_back(pick_char("ABCDHFab"));
        end
        1: begin
          body.push_back(CH_SS3);
          body.push_back(pick_char("ABCDHFMPQRS"));
        end
        2: begin
          body.push_back(CH_LBRACK);
          case ($urandom_range(0, 3))
            0: body.push_back(pick_char("13456"));
            1: begin
              body.push_back(CH_ONE);
              body.push_back(pick_char("1234"));
            end
            2: digits = $sformatf("%0d", $urandom_range(0, 30));
            default: digits = $sformatf("%0d", $urandom_range(0, 99999));
          endcase
          for (int i = 0; i < digits.len(); i++) body.push_back(digits[i]);
          body.push_back(CH_TILDE);
        end
        3: begin
          body.push_back(CH_LBRACK);
          body.push_back(CH_ONE);
          body.push_back(CH_SEMI);
          body.push_back(CH_TWO);
          body.push_back(pick_char("AB"));
        end
        4: begin
          // long parameter run, often enough to fill the buffer
          body.push_back(CH_LBRACK);
          n = $urandom_range(1, 18);
          for (int i = 0; i < n; i++) body.push_back(pick_char("0123456789;?"));
          if ($urandom_range(0, 1)) body.push_back(pick_char("ABz~"));
        end
        5: body.push_back(8'($urandom_range(0, 255)));
        default: begin
          body.push_back(pick_char("[O"));
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) body.push_back(pick_char("0123456789;~ABab"));
        end
      endcase
      foreach (body[i]) begin
        if (i > 0 && $urandom_range(0, 5) == 0) queue_ticks($urandom_range(0, cap));
        queue_byte(body[i]);
      end
    end else if (pick < 88) begin
      // sequence closed by silence (for a delay of 48 ticks or less), resize or end
      queue_byte(CH_ESC);
      case ($urandom_range(0, 4))
        0: ;
        1: queue_byte(CH_LBRACK);
        2: queue_byte(CH_SS3);
        3: begin
          queue_byte(CH_LBRACK);
          queue_byte(CH_ONE);
        end
        default: begin
          queue_byte(CH_LBRACK);
          queue_byte(CH_ONE);
          queue_byte(CH_SEMI);
          queue_byte(CH_TWO);
        end
      endcase
      case ($urandom_range(0, 2))
        0: queue_ticks((delay_ticks == 0) ? 1 :
                       (delay_ticks <= 48) ? delay_ticks : $urandom_range(1, 8));
        1: queue_request(CMD_RESIZE, 8'($urandom_range(0, 255)));
        default: queue_request(CMD_END, 8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 94) begin
      queue_ticks($urandom_range(1, 4));
    end else if (pick < 97) begin
      queue_request(CMD_RESIZE, 8'($urandom_range(0, 255)));
    end else begin
      queue_request(CMD_END, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = queued + n;
    while (queued < target) queue_random_unit();
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || in_valid || pending_keys.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_delay(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sequencer
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset delay: field extremes, idle commands, utf8, basic sequences
    queue_byte(8'h00);
    queue_byte(8'hBF);
    queue_byte(CH_DEL);
    queue_request(CMD_TICK, 8'hFF);
    queue_request(CMD_RESIZE, 8'h00);
    queue_request(CMD_END, 8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'hC3);
    queue_request(CMD_END, 8'h00);
    queue_byte(CH_ESC);
    queue_byte(CH_LBRACK);
    queue_byte("A");
    queue_byte(CH_ESC);
    queue_byte(CH_SS3);
    queue_byte("P");
    queue_byte(CH_ESC);
    queue_byte("x");
    queue_byte(CH_ESC);
    queue_byte(CH_LBRACK);
    queue_request(CMD_RESIZE, 8'hFF);
    run_random(200);
    wait_drained();

    // zero delay: first tick closes, tilde number saturation
    write_delay(16'd0);
    queue_byte(CH_ESC);
    queue_request(CMD_TICK, 8'h00);
    queue_byte(CH_ESC);
    queue_byte(CH_LBRACK);
    queue_byte("9");
    queue_byte("9");
    queue_byte("9");
    queue_byte(CH_TILDE);
    run_random(200);
    wait_drained();

    // longest delay: ticks keep a sequence open, a byte restarts the count,
    // a notice closes it
    write_delay(16'hFFFF);
    queue_byte(CH_ESC);
    queue_byte(CH_LBRACK);
    queue_byte(CH_ONE);
    queue_ticks(120);
    queue_byte(CH_TILDE);
    queue_byte(CH_ESC);
    queue_byte(CH_SS3);
    queue_ticks(50);
    queue_request(CMD_RESIZE, 8'h00);
    run_random(80);
    wait_drained();

    // receiver holds off while requests keep coming; sender pauses midway
    write_delay(16'd3);
    hold_requests++;
    run_random(150);
    wait_drained();
    run_random(150);
    wait_drained();

    write_delay(16'd1);
    run_random(200);
    wait_drained();

    write_delay(16'($urandom_range(2, 60)));
    run_random(200);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/tksd_pkg.sv
sv/terminal_key_sequence_decoder.sv
tb/tb.sv
